// File: design/cdbsu_pkg.sv
`default_nettype none

package cdbsu_pkg;

  localparam logic [2:0] OP_RETIRE = 3'd0;
  localparam logic [2:0] OP_RUN    = 3'd1;
  localparam logic [2:0] OP_ADD    = 3'd2;
  localparam logic [2:0] OP_DEL    = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;
  localparam logic [2:0] OP_MODE   = 3'd5;

  localparam logic [2:0] RUN_FREE     = 3'd0;
  localparam logic [2:0] RUN_NSTEPS   = 3'd1;
  localparam logic [2:0] RUN_STEPIN   = 3'd2;
  localparam logic [2:0] RUN_STEPOUT  = 3'd3;
  localparam logic [2:0] RUN_STEPOVER = 3'd4;

  localparam logic [1:0] DBG_DISABLE = 2'd0;
  localparam logic [1:0] DBG_ENABLE  = 2'd1;
  localparam logic [1:0] DBG_RESTART = 2'd2;

  localparam logic [7:0] INSTR_BRK = 8'h00;
  localparam logic [7:0] INSTR_JSR = 8'h20;
  localparam logic [7:0] INSTR_RTI = 8'h40;
  localparam logic [7:0] INSTR_RTS = 8'h60;

  localparam logic [15:0] NO_TARGET = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] retired_pc;
    logic [7:0]  instr_byte;
    logic [2:0]  run_mode;
    logic [15:0] step_count;
    logic [15:0] bp_address;
    logic [1:0]  dbg_mode;
  } in_word_t;

  typedef struct packed {
    logic       halt;
    logic       accepted;
    logic [7:0] call_depth;
  } out_word_t;

endpackage

`default_nettype wire

// File: design/cdbsu_ram.sv
`default_nettype none

module cdbsu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: design/cpu_debug_break_step_unit_top.sv
`default_nettype none
// channel | signals                      | direction | word
// in      | in_valid, in_stall, in_word  | to unit   | cdbsu_pkg::in_word_t
// out     | out_valid, out_stall, out_word | from unit | cdbsu_pkg::out_word_t
//
// One word per cycle while not stalled; a step-out run command with a nonempty return stack
// waits in S_READ for the stack read through the single RAM read port.
// Every input word gives exactly one output word, held in an output register.
// rst is synchronous; breakpoint slots reset to empty, the stack RAM is not cleared.
// out_stall holds the output register; input is stalled while it is full and held
// by out_stall, or while a stack read is pending.

module cpu_debug_break_step_unit_top #(
  parameter int STACK_DEPTH     = 128,
  parameter int NUM_BREAKPOINTS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire cdbsu_pkg::in_word_t  in_word,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output cdbsu_pkg::out_word_t      out_word
);

  localparam int SW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int BW = (NUM_BREAKPOINTS > 1) ? $clog2(NUM_BREAKPOINTS) : 1;

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t        state;
  logic          debug_enabled, debug_enabled_next;
  logic          saved_enabled, saved_enabled_next;
  logic          stop_flag, stop_flag_next;
  logic [2:0]    armed_mode, armed_mode_next;
  logic [15:0]   steps_left, steps_left_next;
  logic [SW-1:0] stack_top, stack_top_next;
  logic [15:0]   last_pc, last_pc_next;
  logic [7:0]    last_instr, last_instr_next;
  logic [15:0]   step_out_target, step_out_target_next;
  logic [15:0]   step_over_target, step_over_target_next;
  logic [15:0]   slots [NUM_BREAKPOINTS];
  logic [15:0]   slots_next [NUM_BREAKPOINTS];

  logic          in_fire, out_free, rd_pending, acc;
  logic          out_load;
  logic          wr_en;
  logic [SW-1:0] top_m1;
  logic [15:0]   rd_data;
  logic          pc_hit, bp_present, free_found, match_found;
  logic [BW-1:0] free_idx, match_idx;
  logic [15:0]   steps_dec;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign in_fire  = in_valid && !in_stall;
  assign top_m1   = stack_top - SW'(1);
  assign out_load = (state == S_IDLE) ? (in_fire && !rd_pending) : out_free;

  cdbsu_ram #(
    .WIDTH (16),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (stack_top[AW-1:0]),
    .wr_data (in_word.retired_pc + 16'd2),
    .rd_addr (top_m1[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    pc_hit      = 1'b0;
    bp_present  = 1'b0;
    free_found  = 1'b0;
    match_found = 1'b0;
    free_idx    = '0;
    match_idx   = '0;
    for (int i = NUM_BREAKPOINTS - 1; i >= 0; i--) begin
      if (slots[i] == in_word.retired_pc) begin
        pc_hit = 1'b1;
      end
      if (slots[i] == in_word.bp_address) begin
        bp_present  = 1'b1;
        match_found = 1'b1;
        match_idx   = BW'(i);
      end
      if (slots[i] == cdbsu_pkg::NO_TARGET) begin
        free_found = 1'b1;
        free_idx   = BW'(i);
      end
    end
  end

  assign steps_dec = (steps_left != 16'd0) ? steps_left - 16'd1 : 16'd0;

  always_comb begin
    debug_enabled_next    = debug_enabled;
    saved_enabled_next    = saved_enabled;
    stop_flag_next        = stop_flag;
    armed_mode_next       = armed_mode;
    steps_left_next       = steps_left;
    stack_top_next        = stack_top;
    last_pc_next          = last_pc;
    last_instr_next       = last_instr;
    step_out_target_next  = step_out_target;
    step_over_target_next = step_over_target;
    slots_next            = slots;
    wr_en                 = 1'b0;
    rd_pending            = 1'b0;
    acc                   = 1'b1;
    case (in_word.opcode)
      cdbsu_pkg::OP_RETIRE: begin
        if (debug_enabled) begin
          last_pc_next    = in_word.retired_pc;
          last_instr_next = in_word.instr_byte;
          if (in_word.instr_byte == cdbsu_pkg::INSTR_BRK ||
              in_word.instr_byte == cdbsu_pkg::INSTR_JSR) begin
            if (stack_top < SW'(STACK_DEPTH)) begin
              wr_en          = in_fire;
              stack_top_next = stack_top + SW'(1);
            end
          end else if (in_word.instr_byte == cdbsu_pkg::INSTR_RTI ||
                       in_word.instr_byte == cdbsu_pkg::INSTR_RTS) begin
            if (stack_top != '0) begin
              stack_top_next = top_m1;
            end
          end
          case (armed_mode)
            cdbsu_pkg::RUN_NSTEPS: begin
              steps_left_next = steps_dec;
              stop_flag_next  = (steps_dec == 16'd0);
            end
            cdbsu_pkg::RUN_STEPIN: begin
              stop_flag_next = 1'b1;
            end
            cdbsu_pkg::RUN_STEPOUT: begin
              if (step_out_target != cdbsu_pkg::NO_TARGET &&
                  (in_word.retired_pc == step_out_target ||
                   in_word.retired_pc == step_out_target + 16'd1)) begin
                stop_flag_next = 1'b1;
              end
            end
            cdbsu_pkg::RUN_STEPOVER: begin
              if (step_over_target == cdbsu_pkg::NO_TARGET ||
                  in_word.retired_pc == step_over_target) begin
                stop_flag_next = 1'b1;
              end
            end
            default: begin
            end
          endcase
          if (pc_hit) begin
            stop_flag_next = 1'b1;
          end
        end
      end
      cdbsu_pkg::OP_RUN: begin
        armed_mode_next = in_word.run_mode;
        case (in_word.run_mode)
          cdbsu_pkg::RUN_NSTEPS: begin
            steps_left_next = in_word.step_count;
            stop_flag_next  = (in_word.step_count == 16'd0);
          end
          cdbsu_pkg::RUN_STEPOUT: begin
            stop_flag_next = 1'b0;
            if (stack_top != '0) begin
              rd_pending = 1'b1;
            end else begin
              step_out_target_next = cdbsu_pkg::NO_TARGET;
            end
          end
          cdbsu_pkg::RUN_STEPOVER: begin
            stop_flag_next = 1'b0;
            if (last_instr == cdbsu_pkg::INSTR_BRK) begin
              step_over_target_next = last_pc + 16'd1;
            end else if (last_instr == cdbsu_pkg::INSTR_JSR) begin
              step_over_target_next = last_pc + 16'd3;
            end else begin
              step_over_target_next = cdbsu_pkg::NO_TARGET;
            end
          end
          default: begin
            stop_flag_next = 1'b0;
          end
        endcase
      end
      cdbsu_pkg::OP_ADD: begin
        if (!bp_present) begin
          if (free_found) begin
            slots_next[free_idx] = in_word.bp_address;
          end else begin
            acc = 1'b0;
          end
        end
      end
      cdbsu_pkg::OP_DEL: begin
        if (match_found) begin
          slots_next[match_idx] = cdbsu_pkg::NO_TARGET;
        end
      end
      cdbsu_pkg::OP_CLEAR: begin
        for (int i = 0; i < NUM_BREAKPOINTS; i++) begin
          slots_next[i] = cdbsu_pkg::NO_TARGET;
        end
      end
      cdbsu_pkg::OP_MODE: begin
        case (in_word.dbg_mode)
          cdbsu_pkg::DBG_DISABLE: begin
            saved_enabled_next = debug_enabled;
            debug_enabled_next = 1'b0;
            stop_flag_next     = 1'b0;
          end
          cdbsu_pkg::DBG_ENABLE: begin
            debug_enabled_next = 1'b1;
          end
          cdbsu_pkg::DBG_RESTART: begin
            stack_top_next     = '0;
            debug_enabled_next = saved_enabled;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      debug_enabled    <= 1'b0;
      saved_enabled    <= 1'b0;
      stop_flag        <= 1'b0;
      armed_mode       <= cdbsu_pkg::RUN_FREE;
      steps_left       <= 16'd0;
      stack_top        <= '0;
      last_pc          <= 16'd0;
      last_instr       <= 8'd0;
      step_out_target  <= cdbsu_pkg::NO_TARGET;
      step_over_target <= cdbsu_pkg::NO_TARGET;
      for (int i = 0; i < NUM_BREAKPOINTS; i++) begin
        slots[i] <= cdbsu_pkg::NO_TARGET;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            debug_enabled    <= debug_enabled_next;
            saved_enabled    <= saved_enabled_next;
            stop_flag        <= stop_flag_next;
            armed_mode       <= armed_mode_next;
            steps_left       <= steps_left_next;
            stack_top        <= stack_top_next;
            last_pc          <= last_pc_next;
            last_instr       <= last_instr_next;
            step_out_target  <= step_out_target_next;
            step_over_target <= step_over_target_next;
            slots            <= slots_next;
            if (rd_pending) begin
              state <= S_READ;
            end else begin
              out_word.halt       <= stop_flag_next & debug_enabled_next;
              out_word.accepted   <= acc;
              out_word.call_depth <= 8'(stack_top_next);
            end
          end
        end
        S_READ: begin
          if (out_free) begin
            state               <= S_IDLE;
            step_out_target     <= rd_data;
            out_word.halt       <= stop_flag & debug_enabled;
            out_word.accepted   <= 1'b1;
            out_word.call_depth <= 8'(stack_top);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_top <= SW'(STACK_DEPTH))
    else $error("return stack pointer beyond depth");

  a_read_blocks_input: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> !in_fire)
    else $error("word accepted during stack read");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    state == S_READ && out_free |=> out_valid && step_out_target == $past(rd_data))
    else $error("step-out target not loaded from stack");

  a_disabled_retire: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_word.opcode == cdbsu_pkg::OP_RETIRE && !debug_enabled
    |=> $stable(stack_top) && $stable(last_pc) && $stable(stop_flag))
    else $error("retire changed state while disabled");
`endif

endmodule

`default_nettype wire
